// File: rtl/plsc_pkg.sv
// Package for the peak limiter with cubic soft clip.
// Widths, fixed-point constants and shared types; no dependencies.
package plsc_pkg;

   // Field widths
   localparam int SAMPLE_W = 17;   // signed Q3.14 input sample
   localparam int VOL_W    = 17;   // unsigned Q1.16 volume
   localparam int PCM_W    = 16;   // signed PCM result

   // Limiter gain, Q1.GAIN_FRAC_BITS
   localparam int GAIN_FRAC_BITS = 30;
   localparam int GAIN_W         = GAIN_FRAC_BITS + 1;

   // Shared multiplier: A operand holds |raw| (up to 2^32), B operand the gain
   localparam int RAW_W    = 34;
   localparam int B_W      = (GAIN_W > 31) ? GAIN_W : 31;
   localparam int DIGIT_W  = 16;
   localparam int NDIGITS  = (B_W + DIGIT_W - 1) / DIGIT_W;
   localparam int BPAD_W   = NDIGITS * DIGIT_W;
   localparam int ACC_W    = RAW_W + BPAD_W;
   localparam int MAC_CNT_W = $clog2(NDIGITS + 1);
   localparam int DIV_CNT_W = $clog2(GAIN_FRAC_BITS + 1);

   // Soft clip values in Q.30
   localparam int CLIP_W = 31;     // 0 .. 1.0
   localparam int CUBE_W = 30;     // below 1.0

   // Constants
   localparam logic [VOL_W-1:0]  VOL_ONE   = 17'd65536;
   localparam logic [VOL_W-1:0]  VOL_RESET = 17'd9830;
   localparam logic [RAW_W-1:0]  THR_Q30   = 34'd987842478;
   localparam logic [RAW_W-1:0]  REC_Q32   = 34'd85899;
   localparam logic [B_W-1:0]    PCM_SCALE = B_W'(32200);
   localparam logic [RAW_W-1:0]  ONE_Q30   = 34'd1073741824;
   localparam logic [GAIN_W-1:0] GAIN_ONE  = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   // Core handshake status toward the top level
   typedef struct packed {
      logic ready;   // idle, can take a sample
      logic done;    // result word waiting
   } core_stat_type;

endpackage

// File: rtl/peak_limiter_soft_clip_top.sv
// Peak limiter with cubic soft clip, top level: volume register, input
// handshake and output word register. Depends on plsc_pkg, plsc_core.
// Latency from input accept to rsp_valid is longer when the gain is cut than when it
// recovers and shorter when the soft clip saturates; it is set by the digit-serial
// multiplier passes and the one-bit divide steps. The core holds one word at a time.
// It takes a new sample only when idle. Sync reset: volume 9830, gain 1.0.
module peak_limiter_soft_clip_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [plsc_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [plsc_pkg::PCM_W-1:0]    rsp_pcm_out,
   input  logic                          csr_write_enable,
   input  logic [plsc_pkg::VOL_W-1:0]    csr_write_data
);
   import plsc_pkg::*;

   logic [VOL_W-1:0] volume_ff;
   logic             full_ff;
   logic [PCM_W-1:0] pcm_ff;
   core_stat_type    stat;
   logic [PCM_W-1:0] core_pcm;
   logic             take;
   logic             start;

   assign start     = req_valid && stat.ready;
   assign req_stall = !stat.ready;
   // move a finished word into the output register when it is free
   assign take      = stat.done && (!full_ff || !rsp_stall);

   plsc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sample_in (req_sample_in),
      .volume    (volume_ff),
      .take      (take),
      .stat      (stat),
      .pcm_out   (core_pcm)
   );

   // volume register
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOL_RESET;
      end else if (csr_write_enable) begin
         volume_ff <= csr_write_data;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else if (take) begin
         full_ff <= 1'b1;
      end else if (!rsp_stall) begin
         full_ff <= 1'b0;
      end
      if (take) begin
         pcm_ff <= core_pcm;
      end
   end

   assign rsp_valid   = full_ff;
   assign rsp_pcm_out = pcm_ff;

endmodule

// File: rtl/plsc_mac.sv
// Shared multiplier for the peak limiter: digit-serial A * B, one 16-bit digit
// of B per cycle, most significant first. Depends on plsc_pkg.
module plsc_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [plsc_pkg::RAW_W-1:0]  op_a,
   input  logic [plsc_pkg::B_W-1:0]    op_b,
   output logic                        done,
   output logic [plsc_pkg::ACC_W-1:0]  product
);
   import plsc_pkg::*;

   logic [RAW_W-1:0]         a_ff;
   logic [BPAD_W-1:0]        b_ff, b_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [MAC_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   logic [RAW_W+DIGIT_W-1:0] part;
   logic [ACC_W-1:0]         acc_shift;

   // one partial product per cycle, accumulated Horner style
   always_comb begin
      part      = a_ff * b_ff[BPAD_W-1 -: DIGIT_W];
      acc_shift = {acc_ff[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      acc_in    = acc_ff;
      b_in      = b_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in = '0;
         b_in   = BPAD_W'(op_b);
         cnt_in = MAC_CNT_W'(NDIGITS);
      end else if (cnt_ff != '0) begin
         acc_in  = acc_shift + ACC_W'(part);
         b_in    = {b_ff[BPAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == MAC_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      if (start) begin
         a_ff <= op_a;
      end
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// File: rtl/plsc_core.sv
// Sequencer and datapath of the peak limiter: volume scale, gain update,
// restoring divide, cubic soft clip and PCM scaling. Depends on plsc_pkg, plsc_mac.
module plsc_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [plsc_pkg::SAMPLE_W-1:0] sample_in,
   input  logic [plsc_pkg::VOL_W-1:0]    volume,
   input  logic                          take,
   output plsc_pkg::core_stat_type       stat,
   output logic [plsc_pkg::PCM_W-1:0]    pcm_out
);
   import plsc_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_RAW  = 10'b0000000010,
      ST_MAG  = 10'b0000000100,
      ST_REC  = 10'b0000001000,
      ST_DIV  = 10'b0000010000,
      ST_LIM  = 10'b0000100000,
      ST_SQ   = 10'b0001000000,
      ST_CUBE = 10'b0010000000,
      ST_PCM  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type              state_ff, state_in;
   logic                   wait_ff, wait_in;
   logic                   neg_ff, neg_in;
   logic [SAMPLE_W-1:0]    smag_ff, smag_in;
   logic [RAW_W-1:0]       araw_ff, araw_in;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic [RAW_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [CUBE_W-1:0]      m_ff, m_in;
   logic [CUBE_W-1:0]      m2_ff, m2_in;
   logic [CLIP_W-1:0]      c_ff, c_in;
   logic [PCM_W-1:0]       pcm_ff, pcm_in;

   logic                   mac_start, mac_done, mul_state;
   logic [RAW_W-1:0]       mac_a;
   logic [B_W-1:0]         mac_b;
   logic [ACC_W-1:0]       product;

   logic [VOL_W-1:0]       vol_clamp;
   logic [GAIN_W-1:0]      g_clamp;
   logic [RAW_W-1:0]       prod_f;
   logic [GAIN_W-1:0]      rec_inc;
   logic [GAIN_W:0]        gain_sum;
   logic [CUBE_W-1:0]      prod_q30;
   logic [CLIP_W:0]        tri_m, clip_diff;
   logic [PCM_W-2:0]       pcm_mag;
   logic [RAW_W-1:0]       rem_shift;
   logic [SAMPLE_W-1:0]    s_neg;

   plsc_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mac_start),
      .op_a    (mac_a),
      .op_b    (mac_b),
      .done    (mac_done),
      .product (product)
   );

   // clamps and product slices
   always_comb begin
      vol_clamp = (volume > VOL_ONE) ? VOL_ONE : volume;
      g_clamp   = (gain_ff > GAIN_ONE) ? GAIN_ONE : gain_ff;
      prod_f    = product[GAIN_FRAC_BITS +: RAW_W];
      rec_inc   = product[32 +: GAIN_W];
      gain_sum  = {1'b0, g_clamp} + {1'b0, rec_inc};
      prod_q30  = product[30 +: CUBE_W];
      pcm_mag   = product[30 +: PCM_W-1];
      rem_shift = {rem_ff[RAW_W-2:0], 1'b0};
      s_neg     = ~sample_in + 1'b1;
      // 3m - m3, then halve
      tri_m     = {1'b0, m_ff, 1'b0} + (CLIP_W+1)'(m_ff);
      clip_diff = tri_m - (CLIP_W+1)'(prod_q30);
   end

   // multiplier operand select
   always_comb begin
      mul_state = 1'b1;
      mac_a     = '0;
      mac_b     = '0;
      unique case (state_ff)
         ST_RAW: begin
            mac_a = RAW_W'(smag_ff);
            mac_b = B_W'(vol_clamp);
         end
         ST_MAG: begin
            mac_a = araw_ff;
            mac_b = B_W'(g_clamp);
         end
         ST_REC: begin
            mac_a = REC_Q32;
            mac_b = B_W'(GAIN_ONE - g_clamp);
         end
         ST_LIM: begin
            mac_a = araw_ff;
            mac_b = B_W'(gain_ff);
         end
         ST_SQ: begin
            mac_a = RAW_W'(m_ff);
            mac_b = B_W'(m_ff);
         end
         ST_CUBE: begin
            mac_a = RAW_W'(m2_ff);
            mac_b = B_W'(m_ff);
         end
         ST_PCM: begin
            mac_a = RAW_W'(c_ff);
            mac_b = PCM_SCALE;
         end
         default: mul_state = 1'b0;
      endcase
      mac_start = mul_state && !wait_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      wait_in    = wait_ff;
      neg_in     = neg_ff;
      smag_in    = smag_ff;
      araw_in    = araw_ff;
      gain_in    = gain_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      m_in       = m_ff;
      m2_in      = m2_ff;
      c_in       = c_ff;
      pcm_in     = pcm_ff;

      if (mac_start) begin
         wait_in = 1'b1;
      end else if (mul_state && mac_done) begin
         wait_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = sample_in[SAMPLE_W-1];
               smag_in  = sample_in[SAMPLE_W-1] ? s_neg : sample_in;
               state_in = ST_RAW;
            end
         end
         ST_RAW: begin
            if (wait_ff && mac_done) begin
               araw_in  = product[RAW_W-1:0];
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            if (wait_ff && mac_done) begin
               if (prod_f > THR_Q30) begin
                  // cut: gain = 0.92 / |raw|, quotient built one bit a cycle
                  rem_in     = THR_Q30;
                  gain_in    = '0;
                  div_cnt_in = DIV_CNT_W'(GAIN_FRAC_BITS);
                  state_in   = ST_DIV;
               end else begin
                  state_in = ST_REC;
               end
            end
         end
         ST_REC: begin
            if (wait_ff && mac_done) begin
               gain_in  = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE
                                                        : gain_sum[GAIN_W-1:0];
               state_in = ST_LIM;
            end
         end
         ST_DIV: begin
            if (rem_shift >= araw_ff) begin
               rem_in  = rem_shift - araw_ff;
               gain_in = {gain_ff[GAIN_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               gain_in = {gain_ff[GAIN_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               state_in = ST_LIM;
            end
         end
         ST_LIM: begin
            if (wait_ff && mac_done) begin
               if (prod_f >= ONE_Q30) begin
                  // saturated soft clip
                  c_in     = CLIP_W'(ONE_Q30);
                  state_in = ST_PCM;
               end else begin
                  m_in     = prod_f[CUBE_W-1:0];
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            if (wait_ff && mac_done) begin
               m2_in    = prod_q30;
               state_in = ST_CUBE;
            end
         end
         ST_CUBE: begin
            if (wait_ff && mac_done) begin
               c_in     = clip_diff[CLIP_W:1];
               state_in = ST_PCM;
            end
         end
         ST_PCM: begin
            if (wait_ff && mac_done) begin
               pcm_in   = neg_ff ? (PCM_W'(0) - {1'b0, pcm_mag}) : {1'b0, pcm_mag};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wait_ff    <= 1'b0;
         gain_ff    <= GAIN_ONE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         wait_ff    <= wait_in;
         gain_ff    <= gain_in;
         div_cnt_ff <= div_cnt_in;
      end
      neg_ff  <= neg_in;
      smag_ff <= smag_in;
      araw_ff <= araw_in;
      rem_ff  <= rem_in;
      m_ff    <= m_in;
      m2_ff   <= m2_in;
      c_ff    <= c_in;
      pcm_ff  <= pcm_in;
   end

   assign stat.ready = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign pcm_out    = pcm_ff;

endmodule

// File: test/testbench.sv
// Testbench for peak_limiter_soft_clip_top: directed table, then random phases
// at several volume settings, each word checked against a bit-exact predictor or a
// hand-typed word. Depends on plsc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
   import plsc_pkg::*;

   localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake
   localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int SETTLE       = 8;     // idle cycles before a volume write
   localparam int TAIL         = 60;    // cycles after the last word
   localparam int PHASE_WORDS  = 150;
   localparam int NUM_PHASES   = 9;
   localparam int VOL_PICK     = -1;    // phase volume drawn at random
   localparam logic [63:0] GAIN_UNITY = 64'd1 << GAIN_FRAC_BITS;

   typedef enum logic {ROW_VOLUME, ROW_SAMPLE} row_kind_type;
   typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_type;

   typedef struct packed {
      row_kind_type kind;
      logic [31:0]  value;   // volume or sample
      logic         fixed;   // expected word typed in below
      logic [15:0]  pcm;
   } drill_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [PCM_W-1:0]    rsp_pcm_out;
   logic                csr_write_enable;
   logic [VOL_W-1:0]    csr_write_data;

   // side band of the directed table: expected word typed in by hand
   logic                fixed_now;
   logic [PCM_W-1:0]    fixed_pcm;

   logic [VOL_W-1:0]    vol_model;
   logic [63:0]         gain_model;
   logic [PCM_W-1:0]    pcm_due [$];
   int                  mismatches = 0;
   int                  words_out = 0;

   // Directed table: extremes of sample and volume, zero samples, cut and
   // recovery, volume above one
   drill_row_type drill_plan [24] = '{
      '{ROW_SAMPLE, 0,       1'b1, 16'd0},
      '{ROW_SAMPLE, 65535,   1'b0, 16'd0},
      '{ROW_SAMPLE, -65536,  1'b0, 16'd0},
      '{ROW_SAMPLE, 1,       1'b0, 16'd0},
      '{ROW_SAMPLE, -1,      1'b0, 16'd0},
      '{ROW_SAMPLE, 0,       1'b1, 16'd0},
      '{ROW_VOLUME, 0,       1'b0, 16'd0},
      '{ROW_SAMPLE, 65535,   1'b1, 16'd0},
      '{ROW_SAMPLE, -65536,  1'b1, 16'd0},
      '{ROW_SAMPLE, 21845,   1'b1, 16'd0},
      '{ROW_VOLUME, 65536,   1'b0, 16'd0},
      '{ROW_SAMPLE, 16384,   1'b0, 16'd0},
      '{ROW_SAMPLE, -16384,  1'b0, 16'd0},
      '{ROW_SAMPLE, 0,       1'b1, 16'd0},
      '{ROW_SAMPLE, 8000,    1'b0, 16'd0},
      '{ROW_VOLUME, 131071,  1'b0, 16'd0},
      '{ROW_SAMPLE, -14000,  1'b0, 16'd0},
      '{ROW_SAMPLE, 12000,   1'b0, 16'd0},
      '{ROW_VOLUME, 1,       1'b0, 16'd0},
      '{ROW_SAMPLE, 65535,   1'b0, 16'd0},
      '{ROW_SAMPLE, -43691,  1'b0, 16'd0},
      '{ROW_SAMPLE, 43690,   1'b0, 16'd0},
      '{ROW_VOLUME, 9830,    1'b0, 16'd0},
      '{ROW_SAMPLE, -12345,  1'b0, 16'd0}
   };

   // Random phases: volume and share of peaks set per phase
   int phase_vol  [NUM_PHASES] = '{9830, 1, 0, 20000, 32768, 45000, VOL_PICK, 65536, 131071};
   int phase_loud [NUM_PHASES] = '{5, 20, 30, 10, 15, 20, 30, 40, 60};

   peak_limiter_soft_clip_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pcm_out      (rsp_pcm_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gain update, limiting and soft clip for one sample; advances the gain
   function automatic logic [PCM_W-1:0] limit_and_clip(input logic [SAMPLE_W-1:0] s);
      logic         neg;
      logic [63:0]  smag, vol, araw, g, mag, m, m2, m3, c, p, rem;
      logic [127:0] prod;
      neg  = s[SAMPLE_W-1];
      smag = neg ? (64'h20000 - 64'(s)) : 64'(s);
      vol  = (vol_model > VOL_ONE) ? 64'(VOL_ONE) : 64'(vol_model);
      araw = smag * vol;
      g    = (gain_model > GAIN_UNITY) ? GAIN_UNITY : gain_model;
      prod = 128'(araw) * 128'(g);
      mag  = 64'(prod >> GAIN_FRAC_BITS);
      if (mag > 64'(THR_Q30)) begin
         // restoring divide: threshold over |raw|, one bit per step
         rem = 64'(THR_Q30);
         g   = 64'd0;
         for (int i = 0; i < GAIN_FRAC_BITS; i++) begin
            rem = rem << 1;
            g   = g << 1;
            if (rem >= araw) begin
               rem  = rem - araw;
               g[0] = 1'b1;
            end
         end
      end else begin
         g = g + (((GAIN_UNITY - g) * 64'(REC_Q32)) >> 32);
      end
      if (g > GAIN_UNITY) g = GAIN_UNITY;
      gain_model = g;

      prod = 128'(araw) * 128'(g);
      m    = 64'(prod >> GAIN_FRAC_BITS);
      if (araw == 64'd0) neg = 1'b0;
      if (m >= 64'(ONE_Q30)) begin
         c = 64'(ONE_Q30);
      end else begin
         m2 = (m * m) >> 30;
         m3 = (m2 * m) >> 30;
         c  = (64'd3 * m - m3) >> 1;
      end
      p = (c * 64'(PCM_SCALE)) >> 30;
      return neg ? PCM_W'(64'd0 - p) : PCM_W'(p);
   endfunction

   // Random sample: peaks near full scale, silence, quiet passages, anything
   function automatic logic [SAMPLE_W-1:0] draw_sample(input int loud);
      int                  r;
      logic [SAMPLE_W-1:0] s;
      r = $urandom_range(99);
      if (r < loud) begin
         case ($urandom_range(2))
            0: s = 17'h0FFFF;
            1: s = 17'h10000;
            default: begin
               s = SAMPLE_W'($urandom_range(65535, 49152));
               if ($urandom_range(1) == 1) s = -s;
            end
         endcase
      end else if (r < loud + 10) begin
         s = '0;
      end else if (r < loud + 40) begin
         s = SAMPLE_W'($urandom_range(4095));
         if ($urandom_range(1) == 1) s = -s;
      end else begin
         s = SAMPLE_W'($urandom());
      end
      return s;
   endfunction

   task automatic flag_mismatch(input string what, input logic [PCM_W-1:0] got,
                                input logic [PCM_W-1:0] want);
      $display("ERROR word %0d: %s, got %0d expected %0d", words_out, what,
               $signed(got), $signed(want));
      mismatches++;
   endtask

   // Offer one word and hold it until accepted
   task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic fixed,
                            input logic [PCM_W-1:0] pcm);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_sample_in <= s;
      fixed_now     <= fixed;
      fixed_pcm     <= pcm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Drop valid, wait for every word to come back, let the block settle
   task automatic wait_idle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pcm_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_volume(input logic [VOL_W-1:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Predict on each accepted sample, compare each accepted word
   always @(posedge clock) begin : scoreboard
      logic [PCM_W-1:0] want;
      if (reset) begin
         vol_model  = VOL_RESET;
         gain_model = GAIN_UNITY;
         pcm_due.delete();
      end else begin
         if (csr_write_enable) vol_model = csr_write_data;
         if (req_valid && !req_stall) begin
            want = limit_and_clip(req_sample_in);
            if (fixed_now) want = fixed_pcm;
            pcm_due.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pcm_due.size() == 0) begin
               flag_mismatch("no word expected", rsp_pcm_out, '0);
            end else begin
               want = pcm_due.pop_front();
               if (rsp_pcm_out !== want) flag_mismatch("pcm_out", rsp_pcm_out, want);
            end
            words_out++;
         end
      end
   end

   // Receiver: stall patterns of its own, with a long hold-off now and then
   initial begin : receiver
      int       seg, len;
      flow_type mode;
      rsp_stall = 1'b0;
      seg = 0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      forever begin
         seg++;
         if (seg % 25 == 4) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            mode = flow_type'($urandom_range(3));
            len  = $urandom_range(200, 20);
            for (int k = 0; k < len; k++) begin
               @(negedge clock);
               case (mode)
                  FLOW_FREE:  rsp_stall <= 1'b0;
                  FLOW_LIGHT: rsp_stall <= ($urandom_range(99) < 30);
                  FLOW_HEAVY: rsp_stall <= ($urandom_range(99) < 75);
                  default:    rsp_stall <= ((k % 7) < 3);
               endcase
            end
         end
      end
   end

   // Watchdog: ends the run after a long stretch with no handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // Stimulus: reset, directed table, random phases, drain
   initial begin : stimulus
      int burst_left;
      int vol;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_in    = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      fixed_now        = 1'b0;
      fixed_pcm        = '0;
      burst_left       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (drill_plan[i]) begin
         if (drill_plan[i].kind == ROW_VOLUME) begin
            wait_idle();
            write_volume(VOL_W'(drill_plan[i].value));
         end else begin
            send_word(SAMPLE_W'(drill_plan[i].value), drill_plan[i].fixed,
                      drill_plan[i].pcm);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         vol = (phase_vol[ph] == VOL_PICK) ? $urandom_range(131071) : phase_vol[ph];
         write_volume(VOL_W'(vol));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // bursts of random length; about a third without a gap before them
            if (burst_left == 0) begin
               burst_left = $urandom_range(24, 1);
               if ($urandom_range(99) >= 30) idle_gap($urandom_range(10, 1));
            end
            burst_left--;
            send_word(draw_sample(phase_loud[ph]), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pcm_due.size() != 0) @(posedge clock);
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0 && pcm_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
